>>> src/u8sd_pkg.sv
// u8sd_pkg: shared constants and types for the utf8 stream decoder
// no dependencies; imported by every module of the block

package u8sd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 21;
  localparam int unsigned CntW   = 3;   // up to four results per input byte
  localparam int unsigned SeqW   = 2;

  localparam logic [CpW-1:0] ReplChar = 21'h00FFFD;

  // description of the results that one input byte causes:
  // every result but the last is a replacement character
  typedef struct packed {
    logic [CntW-1:0] cnt;    // number of results, zero for none
    logic [CpW-1:0]  cp;     // code point of the last result
    logic            repl;   // replaced flag of the last result
  } run_t;

endpackage : u8sd_pkg

>>> src/u8sd_if.sv
// u8sd_in_if / u8sd_out_if: valid/ready channels of the utf8 stream decoder
// depends on u8sd_pkg for field widths

interface u8sd_in_if;
  logic                          valid;
  logic                          ready;
  logic [u8sd_pkg::ByteW-1:0]    text_byte;
  logic                          final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface : u8sd_in_if

interface u8sd_out_if;
  logic                          valid;
  logic                          ready;
  logic [u8sd_pkg::CpW-1:0]      code_point;
  logic                          replaced;
  logic                          last_of_run;

  modport source (output valid, output code_point, output replaced, output last_of_run,
                  input ready);
  modport sink   (input valid, input code_point, input replaced, input last_of_run,
                  output ready);
endinterface : u8sd_out_if

>>> src/u8sd_decode.sv
// u8sd_decode: sequence state registers and per-byte decode logic
// depends on u8sd_pkg; produces one run_t per accepted byte

module u8sd_decode (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         take,
  input  logic [u8sd_pkg::ByteW-1:0]   text_byte,
  input  logic                         final_byte,
  output u8sd_pkg::run_t               run
);
  import u8sd_pkg::*;

  logic [CpW-1:0]  partial_r, partial_nxt;
  logic [SeqW-1:0] need_r, need_nxt;
  logic [SeqW-1:0] taken_r, taken_nxt;

  // fresh-byte classification
  logic            is_ascii, lead2, lead3, lead4, is_lead, is_cont;
  logic            fresh_n;
  logic [CpW-1:0]  fresh_cp;
  logic            fresh_repl;
  logic            fresh_open;
  logic [SeqW-1:0] fresh_need;
  logic [CpW-1:0]  fresh_bits;

  // continuation path
  logic [CpW-1:0]  cont_pv;
  logic [SeqW-1:0] cont_need;
  logic [SeqW-1:0] cont_taken;

  assign is_ascii = ~text_byte[7];
  assign lead2    = (text_byte[7:5] == 3'b110);
  assign lead3    = (text_byte[7:4] == 4'b1110);
  assign lead4    = (text_byte[7:3] == 5'b11110);
  assign is_lead  = lead2 | lead3 | lead4;
  assign is_cont  = (text_byte[7:6] == 2'b10);

  // byte handled with nothing pending
  always_comb begin
    fresh_need = 2'd0;
    fresh_bits = '0;
    if (lead2) begin
      fresh_need = 2'd1;
      fresh_bits = {16'd0, text_byte[4:0]};
    end else if (lead3) begin
      fresh_need = 2'd2;
      fresh_bits = {17'd0, text_byte[3:0]};
    end else if (lead4) begin
      fresh_need = 2'd3;
      fresh_bits = {18'd0, text_byte[2:0]};
    end
    fresh_open = is_lead & ~final_byte;
    fresh_n    = ~fresh_open;
    fresh_cp   = is_ascii ? {13'd0, text_byte} : ReplChar;
    fresh_repl = ~is_ascii;
  end

  assign cont_pv    = {partial_r[CpW-7:0], text_byte[5:0]};
  assign cont_need  = need_r - 2'd1;
  assign cont_taken = taken_r + 2'd1;

  // results and next sequence state
  always_comb begin
    run         = '{cnt: '0, cp: ReplChar, repl: 1'b1};
    partial_nxt = '0;
    need_nxt    = '0;
    taken_nxt   = '0;
    if (need_r != 2'd0) begin
      if (is_cont) begin
        if (cont_need == 2'd0) begin
          run = '{cnt: CntW'(1), cp: cont_pv, repl: 1'b0};
        end else if (final_byte) begin
          run.cnt = CntW'(1) + {1'b0, cont_taken};
        end else begin
          partial_nxt = cont_pv;
          need_nxt    = cont_need;
          taken_nxt   = cont_taken;
        end
      end else begin
        // broken sequence: lead and taken continuations replaced, byte reprocessed
        run.cnt = CntW'(1) + {1'b0, taken_r} + {2'b00, fresh_n};
        if (fresh_n) begin
          run.cp   = fresh_cp;
          run.repl = fresh_repl;
        end
        if (fresh_open) begin
          partial_nxt = fresh_bits;
          need_nxt    = fresh_need;
        end
      end
    end else begin
      run = '{cnt: {2'b00, fresh_n}, cp: fresh_cp, repl: fresh_repl};
      if (fresh_open) begin
        partial_nxt = fresh_bits;
        need_nxt    = fresh_need;
      end
    end
  end

  // sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      need_r    <= '0;
      taken_r   <= '0;
    end else if (take) begin
      partial_r <= partial_nxt;
      need_r    <= need_nxt;
      taken_r   <= taken_nxt;
    end
  end

endmodule : u8sd_decode

>>> src/u8sd_emit.sv
// u8sd_emit: result register that plays out one run of results
// depends on u8sd_pkg and u8sd_out_if

module u8sd_emit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  u8sd_pkg::run_t       run,
  output logic                 free,
  u8sd_out_if.source           out_chan
);
  import u8sd_pkg::*;

  logic [CntW-1:0] left_r, left_nxt;
  logic [CpW-1:0]  cp_r;
  logic            repl_r;
  logic            xfer;
  logic            is_last;

  assign is_last = (left_r == CntW'(1));
  assign xfer    = out_chan.valid & out_chan.ready;
  // room for a new run once the current one is gone or leaves this cycle
  assign free    = (left_r == '0) | (is_last & out_chan.ready);

  // result fields: replacements ahead of the last result
  assign out_chan.valid       = (left_r != '0);
  assign out_chan.code_point  = is_last ? cp_r : ReplChar;
  assign out_chan.replaced    = is_last ? repl_r : 1'b1;
  assign out_chan.last_of_run = is_last;

  // remaining count
  always_comb begin
    left_nxt = left_r;
    if (xfer) begin
      left_nxt = left_r - CntW'(1);
    end
    if (load) begin
      left_nxt = run.cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else begin
      left_r <= left_nxt;
    end
  end

  // last-result payload
  always_ff @(posedge clk) begin
    if (load) begin
      cp_r   <= run.cp;
      repl_r <= run.repl;
    end
  end

endmodule : u8sd_emit

>>> src/utf8_stream_decoder_top.sv
// utf8_stream_decoder_top: utf-8 byte stream to code point decoder
// depends on u8sd_pkg, u8sd_if, u8sd_decode, u8sd_emit
//
//   channel    dir  payload                                  kind
//   in_chan    in   text_byte[7:0], final_byte               valid/ready
//   out_chan   out  code_point[20:0], replaced, last_of_run  valid/ready
//
// one byte is accepted per cycle while each byte yields at most one result and out_ready is high;
// a byte that yields n results (n up to 4) holds the input until its last result transfers,
// the result register playing out one result per transfer.
// a byte can be taken in the cycle its predecessor's last result transfers.
// reset is synchronous, active low, and leaves no sequence pending.
// out_ready low stalls the result register and then the input.

module utf8_stream_decoder_top (
  input  logic         clk,
  input  logic         rst_n,
  u8sd_in_if.sink      in_chan,
  u8sd_out_if.source   out_chan
);
  import u8sd_pkg::*;

  run_t run;
  logic free;
  logic take;

  assign in_chan.ready = free;
  assign take          = in_chan.valid & free;

  u8sd_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .text_byte  (in_chan.text_byte),
    .final_byte (in_chan.final_byte),
    .run        (run)
  );

  u8sd_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (take),
    .run      (run),
    .free     (free),
    .out_chan (out_chan)
  );

endmodule : utf8_stream_decoder_top

>>> src/u8sd_check.sv
// u8sd_check: port-level assertions for the utf8 stream decoder
// depends on u8sd_pkg; bound to utf8_stream_decoder_top

module u8sd_check (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_ready,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [u8sd_pkg::CpW-1:0]    code_point,
  input  logic                        replaced,
  input  logic                        last_of_run
);
  import u8sd_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(code_point) && $stable(replaced)
      && $stable(last_of_run))
    else $error("result changed while stalled");

  // only the last result of a run may be a real code point
  a_lead_repl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !last_of_run |-> replaced && code_point == ReplChar)
    else $error("non-final result is not a replacement");

  // input is held while more than one result of a run remains
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !last_of_run |-> !in_ready)
    else $error("input taken while a run is still playing out");

  // reset empties the result register
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule : u8sd_check

bind utf8_stream_decoder_top u8sd_check u_check (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .code_point  (out_chan.code_point),
  .replaced    (out_chan.replaced),
  .last_of_run (out_chan.last_of_run)
);

>>> test/tb.sv
`timescale 1ns / 100ps
// tb: self-checking testbench for utf8_stream_decoder_top, byte stream in, code points out
// depends on u8sd_pkg, u8sd_if and the decoder rtl; a small scoreboard class predicts the results

module tb;
  import u8sd_pkg::*;

  localparam int HoldCycles = 300;
  localparam int StallLimit = 2000;
  localparam int RandomItems = 385;

  typedef struct {
    logic [ByteW-1:0] text;
    logic             fin;
  } text_item_t;

  typedef struct {
    logic [CpW-1:0] cp;
    logic           repl;
    logic           last;
  } cp_result_t;

  // decoder prediction plus in-order comparison of the result transfers
  class cp_scoreboard;
    cp_result_t       due_points[$];
    cp_result_t       byte_run[$];
    logic [CpW-1:0]   partial = '0;
    logic [SeqW-1:0]  need = '0;
    logic [SeqW-1:0]  taken = '0;
    int               mismatches = 0;
    int               points_checked = 0;
    int               repl_checked = 0;
    int               bytes_noted = 0;

    function void add_point(logic [CpW-1:0] cp, logic repl);
      byte_run.push_back('{cp: cp, repl: repl, last: 1'b0});
    endfunction

    function void drop_seq();
      partial = '0;
      need = '0;
      taken = '0;
    endfunction

    // byte seen with no sequence open
    function void decode_fresh(logic [ByteW-1:0] b, logic fin);
      logic [SeqW-1:0] n;
      logic [CpW-1:0]  bits;
      if (b[7] == 1'b0) begin
        add_point(CpW'(b), 1'b0);
        return;
      end
      if (b[7:5] == 3'b110) begin
        n = 2'd1;
        bits = CpW'(b[4:0]);
      end else if (b[7:4] == 4'b1110) begin
        n = 2'd2;
        bits = CpW'(b[3:0]);
      end else if (b[7:3] == 5'b11110) begin
        n = 2'd3;
        bits = CpW'(b[2:0]);
      end else begin
        // stray continuation or invalid lead
        add_point(ReplChar, 1'b1);
        return;
      end
      if (fin) begin
        // lead byte cut off by end of text
        add_point(ReplChar, 1'b1);
        return;
      end
      partial = bits;
      need = n;
      taken = '0;
    endfunction

    function void note_byte(text_item_t it);
      bytes_noted++;
      byte_run.delete();
      if (need != 0) begin
        if (it.text[7:6] == 2'b10) begin
          partial = {partial[CpW-7:0], it.text[5:0]};
          need = need - 2'd1;
          taken = taken + 2'd1;
          if (need == 0) begin
            add_point(partial, 1'b0);
            drop_seq();
          end else if (it.fin) begin
            // truncated on a continuation: lead plus every continuation taken
            repeat (1 + taken) add_point(ReplChar, 1'b1);
            drop_seq();
          end
        end else begin
          // broken sequence, then the breaking byte starts over
          repeat (1 + taken) add_point(ReplChar, 1'b1);
          drop_seq();
          decode_fresh(it.text, it.fin);
        end
      end else begin
        decode_fresh(it.text, it.fin);
      end
      if (byte_run.size() > 0) byte_run[byte_run.size()-1].last = 1'b1;
      foreach (byte_run[k]) due_points.push_back(byte_run[k]);
    endfunction

    function void check_result(logic [CpW-1:0] cp, logic repl, logic last);
      cp_result_t want;
      if (due_points.size() == 0) begin
        mismatches++;
        $display("%0t unexpected result: expected none, actual cp %h repl %b last %b",
                 $time, cp, repl, last);
        return;
      end
      want = due_points.pop_front();
      points_checked++;
      if (repl) repl_checked++;
      if (cp !== want.cp) begin
        mismatches++;
        $display("%0t code_point mismatch: expected %h, actual %h", $time, want.cp, cp);
      end
      if (repl !== want.repl) begin
        mismatches++;
        $display("%0t replaced mismatch: expected %b, actual %b", $time, want.repl, repl);
      end
      if (last !== want.last) begin
        mismatches++;
        $display("%0t last_of_run mismatch: expected %b, actual %b", $time, want.last, last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  u8sd_in_if  in_chan();
  u8sd_out_if out_chan();

  utf8_stream_decoder_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  cp_scoreboard sb = new();
  text_item_t   text_items[$];
  bit           hold_req = 1'b0;
  bit           no_gaps = 1'b0;
  int           quiet_cycles = 0;

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("%0t no transfer for %0d cycles", $time, StallLimit);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic logic [ByteW-1:0] lead_of(int len);
    case (len)
      1:       lead_of = {1'b0, 7'($urandom_range(0, 127))};
      2:       lead_of = {3'b110, 5'($urandom_range(0, 31))};
      3:       lead_of = {4'b1110, 4'($urandom_range(0, 15))};
      default: lead_of = {5'b11110, 3'($urandom_range(0, 7))};
    endcase
  endfunction

  function automatic logic [ByteW-1:0] cont_byte();
    return {2'b10, 6'($urandom_range(0, 63))};
  endfunction

  function automatic void add_item(logic [ByteW-1:0] b, logic fin);
    text_items.push_back('{text: b, fin: fin});
  endfunction

  // mostly well-formed characters, plus noise, broken and truncated sequences
  function automatic void build_random_text(int count);
    int kind;
    int len;
    int k;
    logic [ByteW-1:0] b;
    while (text_items.size() < count) begin
      kind = $urandom_range(0, 99);
      len = $urandom_range(1, 4);
      if (kind < 55) begin
        add_item(lead_of(len), len == 1 && $urandom_range(0, 15) == 0);
        for (int j = 1; j < len; j++)
          add_item(cont_byte(), j == len - 1 && $urandom_range(0, 15) == 0);
      end else if (kind < 70) begin
        add_item(ByteW'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
      end else begin
        if (len == 1) len = $urandom_range(2, 4);
        k = $urandom_range(0, len - 2);
        if (kind < 85) begin
          add_item(lead_of(len), 1'b0);
          repeat (k) add_item(cont_byte(), 1'b0);
          do b = ByteW'($urandom_range(0, 255)); while (b[7:6] == 2'b10);
          add_item(b, $urandom_range(0, 7) == 0);
        end else begin
          // end of text arrives before the sequence completes
          add_item(lead_of(len), k == 0);
          for (int j = 1; j <= k; j++) add_item(cont_byte(), j == k);
        end
      end
    end
  endfunction

  // offer one byte and wait for its transfer
  task automatic send_byte(text_item_t it);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.text_byte  <= it.text;
    in_chan.final_byte <= it.fin;
    do @(posedge clk); while (!in_chan.ready);
    sb.note_byte(it);
  endtask

  // result side: random stalls, one long hold on request
  initial begin
    int stall;
    out_chan.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HoldCycles;
      end else begin
        stall = no_gaps ? 0 : $urandom_range(0, 13);
      end
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
      sb.check_result(out_chan.code_point, out_chan.replaced, out_chan.last_of_run);
    end
  end

  // stimulus
  initial begin
    int directed_cnt;
    rst_n              <= 1'b0;
    in_chan.valid      <= 1'b0;
    in_chan.text_byte  <= '0;
    in_chan.final_byte <= 1'b0;

    // ascii extremes, each form, largest value, malformed cases
    add_item(8'h00, 1'b0);
    add_item(8'h7F, 1'b0);
    add_item(8'hC2, 1'b0); add_item(8'hA9, 1'b0);
    add_item(8'hE2, 1'b0); add_item(8'h82, 1'b0); add_item(8'hAC, 1'b0);
    add_item(8'hF7, 1'b0); add_item(8'hBF, 1'b0); add_item(8'hBF, 1'b0); add_item(8'hBF, 1'b0);
    add_item(8'h80, 1'b0);
    add_item(8'hFF, 1'b0);
    add_item(8'hE0, 1'b1);
    add_item(8'hC3, 1'b0); add_item(8'hA9, 1'b1);
    add_item(8'h41, 1'b1);
    // four results from one byte: three for the open sequence, one for the bad lead
    add_item(8'hF0, 1'b0); add_item(8'h9F, 1'b0); add_item(8'h98, 1'b0); add_item(8'hFF, 1'b0);
    add_item(8'hE2, 1'b0); add_item(8'h41, 1'b0);
    add_item(8'hF0, 1'b0); add_item(8'h9F, 1'b0); add_item(8'h98, 1'b1);
    directed_cnt = text_items.size();
    build_random_text(directed_cnt + RandomItems);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (text_items[i]) begin
      if (i == directed_cnt + 90) hold_req = 1'b1;
      if (i == directed_cnt + 200) begin
        // drain everything before going on
        in_chan.valid <= 1'b0;
        do @(posedge clk); while (sb.due_points.size() != 0);
      end
      no_gaps = (i >= directed_cnt + 260) && (i < directed_cnt + 330);
      send_byte(text_items[i]);
    end
    in_chan.valid <= 1'b0;
    no_gaps = 1'b0;

    do @(posedge clk); while (sb.due_points.size() != 0);
    repeat (16) @(posedge clk);

    $display("decoded %0d bytes (%0d directed) into %0d code points, %0d of them replacements",
             sb.bytes_noted, directed_cnt, sb.points_checked, sb.repl_checked);
    $display("%0d field mismatches, %0d results still outstanding",
             sb.mismatches, sb.due_points.size());
    if (sb.mismatches == 0 && sb.due_points.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule : tb
